### rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants for the stack machine executor
// Command and status codes, word and stack sizes, controller command struct.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned WORD_WIDTH  = 32;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(WORD_WIDTH + 1);

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [PTR_W-1:0]      ptr_t;

  typedef enum logic [3:0] {
    CMD_PUSH  = 4'd0,
    CMD_POP   = 4'd1,
    CMD_ADD   = 4'd2,
    CMD_SUB   = 4'd3,
    CMD_MUL   = 4'd4,
    CMD_DIV   = 4'd5,
    CMD_DUP   = 4'd6,
    CMD_SWAP  = 4'd7,
    CMD_ROLL  = 4'd8,
    CMD_CLEAR = 4'd9,
    CMD_PRINT = 4'd10
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_POP_EMPTY = 4'd1,
    ST_FEW_OPS  = 4'd2,
    ST_DIV_ZERO = 4'd3,
    ST_DUP_EMPTY = 4'd4,
    ST_ROLL_RANGE = 4'd5,
    ST_UNKNOWN  = 4'd6,
    ST_OVERFLOW = 4'd7,
    ST_HALTED   = 4'd8
  } status_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD,       // read stack entry at rd_addr
    OP_LATCH_B,  // capture read data into B
    OP_LATCH_A,  // capture read data into A
    OP_WR_OPND,  // write operand at wr_addr
    OP_WR_A,     // write A at wr_addr
    OP_WR_B,     // write B at wr_addr
    OP_WR_ALU,   // write add/sub/mul result
    OP_DIV_START,
    OP_WR_DIV
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    ptr_t   rd_addr;
    ptr_t   wr_addr;
    logic   sub;
    logic   mul;
  } dp_cmd_t;

  typedef struct packed {
    word_t rd_data;
    logic  div_done;
    logic  b_zero;
  } dp_sts_t;

endpackage

### rtl/smx_if.sv
// ----------------------------------------------------------------------------
// smx_req_if / smx_rsp_if: valid-ready channels of the stack machine executor
// Request channel carries a command, response channel one result.
// ----------------------------------------------------------------------------
interface smx_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic signed [31:0] operand_value;
  modport source (output valid, output req_type, output operand_value, input ready);
  modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

interface smx_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic signed [31:0] value;
  logic        value_valid;
  logic        last;
  logic [5:0]  depth_now;
  modport source (output valid, output status, output value, output value_valid,
                  output last, output depth_now, input ready);
  modport sink   (input valid, input status, input value, input value_valid,
                  input last, input depth_now, output ready);
endinterface

### rtl/smx_datapath.sv
// ----------------------------------------------------------------------------
// smx_datapath: stack memory, operand registers, ALU and serial divider
// One write and one registered read port on the stack; restoring divider
// producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smx_datapath
  import smx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  input  word_t    operand_i,
  output dp_sts_t  sts_o
);

  word_t mem_q [STACK_DEPTH];
  word_t rd_data_q;
  word_t a_q, b_q;
  word_t alu_q;

  // divider state
  word_t                quo_q, quo_d;
  logic [WORD_WIDTH:0]  rem_q, rem_d;
  word_t                dvs_q;
  logic                 neg_q, busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_WIDTH:0]  trial;
  word_t                a_abs, b_abs, wr_data;

  assign a_abs = a_q[WORD_WIDTH-1] ? word_t'(-a_q) : a_q;
  assign b_abs = b_q[WORD_WIDTH-1] ? word_t'(-b_q) : b_q;

  // write data select
  always_comb begin
    case (cmd_i.op)
      OP_WR_OPND: wr_data = operand_i;
      OP_WR_A:    wr_data = a_q;
      OP_WR_B:    wr_data = b_q;
      OP_WR_ALU:  wr_data = alu_q;
      default:    wr_data = neg_q ? word_t'(-quo_q) : quo_q;
    endcase
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WR_OPND || cmd_i.op == OP_WR_A || cmd_i.op == OP_WR_B ||
        cmd_i.op == OP_WR_ALU || cmd_i.op == OP_WR_DIV) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[cmd_i.rd_addr];
  end

  // operand registers and add/sub/mul result
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH_B) b_q <= rd_data_q;
    if (cmd_i.op == OP_LATCH_A) a_q <= rd_data_q;
    if (cmd_i.mul)      alu_q <= word_t'(a_q * b_q);
    else if (cmd_i.sub) alu_q <= a_q - b_q;
    else                alu_q <= a_q + b_q;
  end

  // restoring divider step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[WORD_WIDTH-1:0], quo_q[WORD_WIDTH-1]};
    if (busy_q) begin
      quo_d = {quo_q[WORD_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.op == OP_DIV_START) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(WORD_WIDTH);
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV_START) begin
      quo_q <= a_abs;
      rem_q <= '0;
      dvs_q <= b_abs;
      neg_q <= a_q[WORD_WIDTH-1] ^ b_q[WORD_WIDTH-1];
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign sts_o.rd_data  = rd_data_q;
  assign sts_o.div_done = !busy_q && (cnt_q == '0);
  assign sts_o.b_zero   = (b_q == '0);

endmodule

### rtl/smx_ctrl.sv
// ----------------------------------------------------------------------------
// smx_ctrl: command sequencer of the stack machine executor
// Decodes a request, steps the datapath through reads, writes, divider and
// roll/print walks, and produces results into a one-entry output register.
// ----------------------------------------------------------------------------
module smx_ctrl
  import smx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  smx_req_if.sink     req,
  smx_rsp_if.source   rsp,
  output dp_cmd_t     cmd_o,
  input  dp_sts_t     sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_LB, S_LA, S_EXEC, S_ALU, S_DIVW, S_DUPW,
    S_ROLL_RD, S_ROLL_MV, S_PRT_RD, S_PRT_OUT, S_DONE
  } state_e;

  state_e  state_q;
  cmd_e    cmd_q;
  cnt_t    cnt_q;
  logic    halted_q;
  ptr_t    idx_q;
  logic    first_q;

  // output register
  logic    ovalid_q;
  status_e ost_q;
  word_t   oval_q;
  logic    ovv_q, olast_q;
  cnt_t    odep_q;

  logic    out_free;
  word_t   opnd_q;
  logic    roll_bad;

  assign out_free  = !ovalid_q || rsp.ready;
  assign req.ready = (state_q == S_IDLE) && out_free;
  assign roll_bad  = (opnd_q[WORD_WIDTH-1] || opnd_q == '0 ||
                      opnd_q > word_t'(cnt_q));

  assign rsp.valid       = ovalid_q;
  assign rsp.status      = ost_q;
  assign rsp.value       = oval_q;
  assign rsp.value_valid = ovv_q;
  assign rsp.last        = olast_q;
  assign rsp.depth_now   = 6'(odep_q);

  // datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    cmd_o.sub     = (cmd_q == CMD_SUB);
    cmd_o.mul     = (cmd_q == CMD_MUL);
    cmd_o.rd_addr = ptr_t'(cnt_q - 1'b1);
    cmd_o.wr_addr = ptr_t'(cnt_q - 2'd2);
    unique case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready && !halted_q &&
            (req.req_type == CMD_PUSH) && cnt_q < cnt_t'(STACK_DEPTH)) begin
          cmd_o.op      = OP_WR_OPND;
          cmd_o.wr_addr = ptr_t'(cnt_q);
        end
        // read top of stack for anything that needs it
        cmd_o.rd_addr = ptr_t'(cnt_q - 1'b1);
      end
      S_RD1: begin
        cmd_o.op      = OP_LATCH_B;
        cmd_o.rd_addr = ptr_t'(cnt_q - 2'd2);
      end
      S_LB: begin
        cmd_o.op = OP_LATCH_A;
      end
      S_LA: begin
        if (cmd_q == CMD_SWAP) begin
          cmd_o.op      = OP_WR_B;
        end else if (cmd_q == CMD_DIV) begin
          cmd_o.op      = sts_i.b_zero ? OP_NONE : OP_DIV_START;
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_SWAP) begin
          cmd_o.op      = OP_WR_A;
          cmd_o.wr_addr = ptr_t'(cnt_q - 1'b1);
        end else begin
          // fetch the entry that rolls to the top
          cmd_o.rd_addr = ptr_t'(cnt_q - cnt_t'(opnd_q));
        end
      end
      S_ALU:  cmd_o.op = OP_WR_ALU;
      S_DIVW: if (sts_i.div_done) cmd_o.op = OP_WR_DIV;
      S_DUPW: begin
        cmd_o.op      = OP_LATCH_B;
      end
      S_ROLL_RD: begin
        cmd_o.op      = OP_LATCH_A;
        cmd_o.rd_addr = ptr_t'(idx_q + 1'b1);
      end
      S_ROLL_MV: begin
        // shift entry idx+1 down to idx, or drop the moved word on top
        if (idx_q == ptr_t'(cnt_q - 1'b1)) begin
          cmd_o.op      = OP_WR_A;
          cmd_o.wr_addr = idx_q;
        end else begin
          cmd_o.op      = OP_LATCH_B;
          cmd_o.rd_addr = ptr_t'(idx_q + 2'd2);
        end
      end
      S_PRT_RD: cmd_o.rd_addr = idx_q;
      S_PRT_OUT: cmd_o.rd_addr = idx_q;
      default: ;
    endcase
    if (state_q == S_DONE && cmd_q == CMD_DUP) begin
      cmd_o.op      = OP_WR_B;
      cmd_o.wr_addr = ptr_t'(cnt_q);
    end
    if (state_q == S_ROLL_MV && idx_q != ptr_t'(cnt_q - 1'b1) && first_q) begin
      cmd_o.op      = OP_WR_B;
      cmd_o.wr_addr = idx_q;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      halted_q <= 1'b0;
      ovalid_q <= 1'b0;
      cmd_q    <= CMD_PUSH;
      idx_q    <= '0;
      first_q  <= 1'b0;
      ost_q    <= ST_OK;
      oval_q   <= '0;
      ovv_q    <= 1'b0;
      olast_q  <= 1'b0;
      odep_q   <= '0;
      opnd_q   <= '0;
    end else begin
      if (rsp.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cmd_q  <= cmd_e'(req.req_type);
            opnd_q <= word_t'(req.operand_value);
            ovv_q  <= 1'b0;
            oval_q <= '0;
            olast_q <= 1'b1;
            ost_q  <= ST_OK;
            if (halted_q) begin
              ost_q <= ST_HALTED; ovalid_q <= 1'b1; odep_q <= cnt_q;
            end else begin
              case (req.req_type)
                CMD_PUSH: begin
                  ovalid_q <= 1'b1;
                  if (cnt_q < cnt_t'(STACK_DEPTH)) begin
                    cnt_q <= cnt_q + 1'b1; odep_q <= cnt_q + 1'b1;
                  end else begin
                    ost_q <= ST_OVERFLOW; odep_q <= cnt_q;
                  end
                end
                CMD_POP: begin
                  ovalid_q <= 1'b1;
                  if (cnt_q == '0) begin
                    ost_q <= ST_POP_EMPTY; odep_q <= cnt_q;
                  end else begin
                    cnt_q <= cnt_q - 1'b1; odep_q <= cnt_q - 1'b1;
                  end
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SWAP: begin
                  if (cnt_q < cnt_t'(2)) begin
                    ost_q <= ST_FEW_OPS; halted_q <= 1'b1;
                    ovalid_q <= 1'b1; odep_q <= cnt_q;
                  end else begin
                    state_q <= S_RD1;
                  end
                end
                CMD_DUP: begin
                  if (cnt_q == '0) begin
                    ost_q <= ST_DUP_EMPTY; halted_q <= 1'b1;
                    ovalid_q <= 1'b1; odep_q <= cnt_q;
                  end else if (cnt_q >= cnt_t'(STACK_DEPTH)) begin
                    ost_q <= ST_OVERFLOW; ovalid_q <= 1'b1; odep_q <= cnt_q;
                  end else begin
                    state_q <= S_DUPW;
                  end
                end
                CMD_ROLL: state_q <= S_EXEC;
                CMD_CLEAR: begin
                  cnt_q <= '0; odep_q <= '0; ovalid_q <= 1'b1;
                end
                CMD_PRINT: begin
                  if (cnt_q == '0) begin
                    ovalid_q <= 1'b1; odep_q <= '0;
                  end else begin
                    idx_q   <= ptr_t'(cnt_q - 1'b1);
                    state_q <= S_PRT_RD;
                  end
                end
                default: begin
                  ost_q <= ST_UNKNOWN; halted_q <= 1'b1;
                  ovalid_q <= 1'b1; odep_q <= cnt_q;
                end
              endcase
            end
          end
        end
        S_RD1: state_q <= S_LB;
        S_LB:  state_q <= S_LA;
        S_LA: begin
          if (cmd_q == CMD_SWAP) state_q <= S_EXEC;
          else if (cmd_q == CMD_DIV) begin
            if (sts_i.b_zero) begin
              cnt_q <= cnt_q - 2'd2; state_q <= S_DONE;
              ost_q <= ST_DIV_ZERO; halted_q <= 1'b1;
            end else begin
              state_q <= S_DIVW;
            end
          end else state_q <= S_ALU;
        end
        S_EXEC: begin
          if (cmd_q == CMD_SWAP) state_q <= S_DONE;
          else if (roll_bad) begin
            ost_q <= ST_ROLL_RANGE; state_q <= S_DONE;
          end else begin
            idx_q   <= ptr_t'(cnt_q - cnt_t'(opnd_q));
            state_q <= S_ROLL_RD;
          end
        end
        S_ALU: begin
          cnt_q <= cnt_q - 1'b1; state_q <= S_DONE;
        end
        S_DIVW: if (sts_i.div_done) begin
          cnt_q <= cnt_q - 1'b1; state_q <= S_DONE;
        end
        S_DUPW: state_q <= S_DONE;
        S_ROLL_RD: begin
          // entry idx lands in A this cycle
          first_q <= 1'b0;
          state_q <= S_ROLL_MV;
        end
        S_ROLL_MV: begin
          if (idx_q == ptr_t'(cnt_q - 1'b1)) begin
            state_q <= S_DONE;
          end else if (first_q) begin
            first_q <= 1'b0;
            idx_q   <= idx_q + 1'b1;
          end else begin
            first_q <= 1'b1;
          end
        end
        S_PRT_RD: state_q <= S_PRT_OUT;
        S_PRT_OUT: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            oval_q   <= sts_i.rd_data;
            ovv_q    <= 1'b1;
            ost_q    <= ST_OK;
            odep_q   <= cnt_q;
            olast_q  <= (idx_q == '0);
            if (idx_q == '0) state_q <= S_IDLE;
            else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= S_PRT_RD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (cmd_q == CMD_DUP) begin
              cnt_q  <= cnt_q + 1'b1;
              odep_q <= cnt_q + 1'b1;
            end else begin
              odep_q <= cnt_q;
            end
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor: RPN stack machine on 32-bit signed words
// Controller plus datapath; one command in flight at a time.
// ----------------------------------------------------------------------------
// A command is taken when the block is idle and its result register is free
// to load. Push, pop, clear and the errors caught at decode are answered
// at decode; add, sub, mul, swap and dup first read the stack; divide is
// set by the bit-serial restoring divider (one quotient bit a cycle) unless
// the divisor is zero; roll and print are set by the single stack read
// port. A stalled response delays the result.
// A fatal error makes every later command answer "halted" until reset.
module stack_machine_executor
  import smx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  smx_req_if.sink   req,
  smx_rsp_if.source rsp
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  smx_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp),
    .cmd_o  (dp_cmd),
    .sts_i  (dp_sts)
  );

  smx_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (dp_cmd),
    .operand_i (word_t'(req.operand_value)),
    .sts_o     (dp_sts)
  );

endmodule

### rtl/smx_checker.sv
// ----------------------------------------------------------------------------
// smx_checker: port-level checks for the stack machine executor
// Watches the response channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module smx_checker
  import smx_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [3:0] rsp_status,
  input logic       rsp_vv,
  input logic [5:0] rsp_depth
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("response changed while stalled");

  // depth never exceeds the stack size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_depth <= 6'(STACK_DEPTH))
    else $error("depth out of range");

  // printed elements always carry ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_vv |-> rsp_status == ST_OK)
    else $error("printed element with error status");

endmodule

bind stack_machine_executor smx_checker u_smx_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_vv     (rsp.value_valid),
  .rsp_depth  (rsp.depth_now)
);
